[rtl/core/rgbcc_pkg.sv]
// rgbcc_pkg: shared types, color codes, register indexes and the tone table
// of the color classifier. No dependencies.
package rgbcc_pkg;

   // shared divider geometry: 16-bit divisor, 10-bit quotient
   localparam int DIVS_W     = 16;
   localparam int QUO_W      = 10;
   localparam int DIVD_W     = DIVS_W + QUO_W;
   localparam int CSR_ADDR_W = 3;

   localparam logic [3:0] COLOR_DARK     = 4'd0;
   localparam logic [3:0] COLOR_WHITE    = 4'd1;
   localparam logic [3:0] COLOR_YELLOW   = 4'd2;
   localparam logic [3:0] COLOR_MAGENTA  = 4'd3;
   localparam logic [3:0] COLOR_CYAN     = 4'd4;
   localparam logic [3:0] COLOR_RED      = 4'd5;
   localparam logic [3:0] COLOR_GREEN    = 4'd6;
   localparam logic [3:0] COLOR_BLUE     = 4'd7;
   localparam logic [3:0] COLOR_UNDEF    = 4'd8;
   localparam logic [3:0] NONE_ANNOUNCED = 4'd15;

   localparam logic REG_LUX_LOW    = 1'b0;
   localparam logic REG_DARK_TOTAL = 1'b1;

   typedef struct packed {
      logic [15:0] red;
      logic [15:0] green;
      logic [15:0] blue;
      logic [15:0] lux;
   } req_type;

   typedef struct packed {
      logic [3:0] color_code;
      logic [9:0] saturation_tenths;
      logic       tone_start;
      logic [9:0] tone_hz;
      logic [7:0] brightness;
      logic [7:0] led_red;
      logic [7:0] led_green;
      logic [7:0] led_blue;
      logic       low_light;
      logic       alert_start;
   } rsp_type;

   typedef struct packed {
      logic [15:0] lux_low_limit;
      logic [17:0] dark_total_limit;
   } cfg_type;

   typedef struct packed {
      logic              start;
      logic [DIVD_W-1:0] dividend;
      logic [DIVS_W-1:0] divisor;
   } div_req_type;

   typedef struct packed {
      logic             done;
      logic [QUO_W-1:0] quotient;
   } div_rsp_type;

   typedef struct packed {
      logic [3:0]  code;
      logic [15:0] max_ch;
      logic [15:0] min_ch;
   } class_type;

   function automatic logic [9:0] tone_hz_of(input logic [3:0] code);
      logic [9:0] hz;
      case (code)
         COLOR_WHITE:   hz = 10'd523;
         COLOR_YELLOW:  hz = 10'd294;
         COLOR_MAGENTA: hz = 10'd349;
         COLOR_CYAN:    hz = 10'd440;
         COLOR_RED:     hz = 10'd262;
         COLOR_GREEN:   hz = 10'd330;
         COLOR_BLUE:    hz = 10'd392;
         default:       hz = 10'd0;
      endcase
      return hz;
   endfunction

endpackage

[rtl/core/rgbcc_csr.sv]
// rgbcc_csr: APB-style register file for the two light limits.
// Depends on rgbcc_pkg.
module rgbcc_csr import rgbcc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready,
   output cfg_type               cfg
);

   cfg_type cfg_ff, cfg_in;
   logic    wr_en;

   assign pready = 1'b1;
   assign wr_en  = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         case (paddr[2])
            REG_LUX_LOW:    cfg_in.lux_low_limit    = pwdata[15:0];
            REG_DARK_TOTAL: cfg_in.dark_total_limit = pwdata[17:0];
            default:        cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_LUX_LOW:    prdata = {16'd0, cfg_ff.lux_low_limit};
         REG_DARK_TOTAL: prdata = {14'd0, cfg_ff.dark_total_limit};
         default:        prdata = 32'd0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.lux_low_limit    <= 16'd50;
         cfg_ff.dark_total_limit <= 18'd100;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

[rtl/core/rgbcc_classify.sv]
// rgbcc_classify: ordered color tests as exact cross-multiplications,
// plus channel max and min. Depends on rgbcc_pkg.
module rgbcc_classify import rgbcc_pkg::*; (
   input  req_type     item,
   input  logic [17:0] dark_limit,
   output class_type   cls
);

   logic [23:0] r, g, b, s, mx, mn;
   logic [3:0]  code;

   always_comb begin
      r  = {8'd0, item.red};
      g  = {8'd0, item.green};
      b  = {8'd0, item.blue};
      s  = r + g + b;
      mx = r;
      if (g > mx) mx = g;
      if (b > mx) mx = b;
      mn = r;
      if (g < mn) mn = g;
      if (b < mn) mn = b;

      if (s < {6'd0, dark_limit})
         code = COLOR_DARK;
      else if (24'd5 * mn > 24'd3 * mx)
         code = COLOR_WHITE;
      else if (24'd5 * r > 24'd4 * mx && 24'd5 * g > 24'd4 * mx && 24'd2 * b < mx)
         code = COLOR_YELLOW;
      else if (24'd5 * r > 24'd4 * mx && 24'd5 * b > 24'd4 * mx && 24'd2 * g < mx)
         code = COLOR_MAGENTA;
      else if (24'd5 * g > 24'd4 * mx && 24'd5 * b > 24'd4 * mx && 24'd2 * r < mx)
         code = COLOR_CYAN;
      else if (24'd5 * r > 24'd6 * g && 24'd5 * r > 24'd6 * b)
         code = COLOR_RED;
      else if (24'd5 * g > 24'd6 * r && 24'd5 * g > 24'd6 * b)
         code = COLOR_GREEN;
      else if (24'd5 * b > 24'd6 * r && 24'd5 * b > 24'd6 * g)
         code = COLOR_BLUE;
      else if (24'd20 * r > 24'd9 * s && 24'd10 * g > 24'd3 * s && 24'd4 * b < s)
         code = COLOR_YELLOW;
      else if (24'd20 * g > 24'd9 * s && 24'd10 * r < 24'd3 * s && 24'd10 * b < 24'd3 * s)
         code = COLOR_GREEN;
      else if (24'd20 * b > 24'd9 * s && 24'd10 * r < 24'd3 * s && 24'd10 * g < 24'd3 * s)
         code = COLOR_BLUE;
      else
         code = COLOR_UNDEF;

      cls.code   = code;
      cls.max_ch = mx[15:0];
      cls.min_ch = mn[15:0];
   end

endmodule

[rtl/core/rgbcc_div.sv]
// rgbcc_div: shared restoring divider, one quotient bit per cycle.
// Needs dividend < divisor * 2**QUO_W. Depends on rgbcc_pkg.
module rgbcc_div import rgbcc_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  div_req_type div_req,
   output div_rsp_type div_rsp
);

   localparam int CNT_W = $clog2(QUO_W);

   logic [DIVS_W-1:0] rem_ff, rem_in, divisor_ff, divisor_in;
   logic [QUO_W-1:0]  low_ff, low_in, quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in, done_ff, done_in;
   logic [DIVS_W:0]   cat, diff;
   logic              fits;

   always_comb begin
      cat  = {rem_ff, low_ff[QUO_W-1]};
      fits = cat >= {1'b0, divisor_ff};
      diff = cat - {1'b0, divisor_ff};

      rem_in     = rem_ff;
      low_in     = low_ff;
      quo_in     = quo_ff;
      divisor_in = divisor_ff;
      cnt_in     = cnt_ff;
      busy_in    = busy_ff;
      done_in    = 1'b0;

      if (div_req.start) begin
         // upper bits already sit below the divisor
         rem_in     = div_req.dividend[DIVD_W-1 -: DIVS_W];
         low_in     = div_req.dividend[QUO_W-1:0];
         divisor_in = div_req.divisor;
         quo_in     = '0;
         cnt_in     = '0;
         busy_in    = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? diff[DIVS_W-1:0] : cat[DIVS_W-1:0];
         low_in = {low_ff[QUO_W-2:0], 1'b0};
         quo_in = {quo_ff[QUO_W-2:0], fits};
         if (cnt_ff == CNT_W'(QUO_W - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
            cnt_in  = '0;
         end else begin
            cnt_in = cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      low_ff     <= low_in;
      quo_ff     <= quo_in;
      divisor_ff <= divisor_in;
   end

   assign div_rsp.done     = done_ff;
   assign div_rsp.quotient = quo_ff;

endmodule

[rtl/core/rgb_color_classifier.sv]
// rgb_color_classifier: top level. Sequencer around one shared divider,
// classifier, register file and output register. Depends on rgbcc_pkg,
// rgbcc_csr, rgbcc_classify and rgbcc_div.
//
//   channel   ports                      direction  payload
//   request   req_valid/req_stall        in         req_type (red green blue lux)
//   response  rsp_valid/rsp_stall        out        rsp_type (color, LEDs, flags)
//   config    psel penable pwrite paddr  in/out     lux_low_limit @0, dark_total_limit @4
//
// An item passes from acceptance to a valid result through a classify step,
// then five divisions in turn on the shared divider (brightness, three LED
// levels, saturation), then a post step that registers the result.
// req_stall stays high from acceptance until the result is posted.
// A stalled result holds in the output register; the block still finishes the
// next item and waits in the post step until the register frees.
// Synchronous reset restores the limits to 50 and 100, forgets the last tone.
module rgb_color_classifier import rgbcc_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output rsp_type               rsp_data,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [31:0]           pwdata,
   output logic [31:0]           prdata,
   output logic                  pready
);

   typedef enum logic [4:0] {
      ST_IDLE     = 5'b00001,
      ST_CLASSIFY = 5'b00010,
      ST_LOAD     = 5'b00100,
      ST_RUN      = 5'b01000,
      ST_FINISH   = 5'b10000
   } state_type;

   // division jobs in issue order; LEDs need the brightness first
   localparam logic [2:0] JOB_BRIGHT = 3'd0;
   localparam logic [2:0] JOB_LED_R  = 3'd1;
   localparam logic [2:0] JOB_LED_G  = 3'd2;
   localparam logic [2:0] JOB_LED_B  = 3'd3;
   localparam logic [2:0] JOB_SAT    = 3'd4;

   localparam logic [15:0] LUX_FLOOR    = 16'd10;
   localparam logic [15:0] LUX_CEIL     = 16'd1000;
   localparam logic [7:0]  BRIGHT_MIN   = 8'd10;
   localparam logic [7:0]  BRIGHT_MAX   = 8'd255;
   localparam int          BRIGHT_SLOPE = 245;
   localparam int          SAT_SCALE    = 1000;

   cfg_type     cfg;
   class_type   cls;
   div_req_type div_req;
   div_rsp_type div_rsp;

   state_type state_ff, state_in;
   req_type   item_ff, item_in;
   class_type cls_ff, cls_in;
   logic [2:0] job_ff, job_in;
   logic [7:0] br_ff, br_in, led_r_ff, led_r_in, led_g_ff, led_g_in, led_b_ff, led_b_in;
   logic [9:0] sat_ff, sat_in;
   logic [3:0] last_ann_ff, last_ann_in;
   logic       alert_latched_ff, alert_latched_in;
   rsp_type    rsp_ff, rsp_in;
   logic       rsp_valid_ff, rsp_valid_in;

   logic [15:0]       ch_sel;
   logic [7:0]        ch_clamp;
   logic [15:0]       led_prod;
   logic [DIVD_W-1:0] lux_prod, sat_prod;
   logic              rsp_free, low, tone;

   rgbcc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   rgbcc_classify u_classify (
      .item       (item_ff),
      .dark_limit (cfg.dark_total_limit),
      .cls        (cls)
   );

   rgbcc_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;
   assign rsp_free  = !rsp_valid_ff || !rsp_stall;

   // operands for the divider: pick channel, clamp to 255, scale by brightness
   always_comb begin
      case (job_ff)
         JOB_LED_R: ch_sel = item_ff.red;
         JOB_LED_G: ch_sel = item_ff.green;
         default:   ch_sel = item_ff.blue;
      endcase
      ch_clamp = (ch_sel > 16'd255) ? 8'd255 : ch_sel[7:0];
      led_prod = {8'd0, ch_clamp} * {8'd0, br_ff};
      lux_prod = DIVD_W'(item_ff.lux) * DIVD_W'(BRIGHT_SLOPE);
      sat_prod = DIVD_W'(cls_ff.max_ch - cls_ff.min_ch) * DIVD_W'(SAT_SCALE);
   end

   always_comb begin
      div_req.start = (state_ff == ST_LOAD);
      case (job_ff)
         JOB_BRIGHT: begin
            div_req.dividend = lux_prod;
            div_req.divisor  = LUX_CEIL;
         end
         JOB_LED_R, JOB_LED_G, JOB_LED_B: begin
            div_req.dividend = DIVD_W'(led_prod);
            div_req.divisor  = DIVS_W'(BRIGHT_MAX);
         end
         JOB_SAT: begin
            div_req.dividend = sat_prod;
            div_req.divisor  = cls_ff.max_ch;
         end
         default: begin
            div_req.dividend = '0;
            div_req.divisor  = '0;
         end
      endcase
   end

   always_comb begin
      state_in         = state_ff;
      item_in          = item_ff;
      cls_in           = cls_ff;
      job_in           = job_ff;
      br_in            = br_ff;
      led_r_in         = led_r_ff;
      led_g_in         = led_g_ff;
      led_b_in         = led_b_ff;
      sat_in           = sat_ff;
      last_ann_in      = last_ann_ff;
      alert_latched_in = alert_latched_ff;
      rsp_in           = rsp_ff;
      rsp_valid_in     = rsp_valid_ff && rsp_stall;

      low  = item_ff.lux < cfg.lux_low_limit;
      tone = (cls_ff.code != COLOR_DARK) && (cls_ff.code != COLOR_UNDEF) &&
             (cls_ff.code != last_ann_ff);

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               item_in  = req_data;
               state_in = ST_CLASSIFY;
            end
         end
         ST_CLASSIFY: begin
            cls_in   = cls;
            job_in   = JOB_BRIGHT;
            state_in = ST_LOAD;
         end
         ST_LOAD: begin
            state_in = ST_RUN;
         end
         ST_RUN: begin
            if (div_rsp.done) begin
               case (job_ff)
                  JOB_BRIGHT: begin
                     if (item_ff.lux < LUX_FLOOR)
                        br_in = BRIGHT_MIN;
                     else if (item_ff.lux > LUX_CEIL)
                        br_in = BRIGHT_MAX;
                     else
                        br_in = BRIGHT_MIN + div_rsp.quotient[7:0];
                  end
                  JOB_LED_R: led_r_in = div_rsp.quotient[7:0];
                  JOB_LED_G: led_g_in = div_rsp.quotient[7:0];
                  JOB_LED_B: led_b_in = div_rsp.quotient[7:0];
                  JOB_SAT:   sat_in = (cls_ff.max_ch == 16'd0) ? 10'd0 : div_rsp.quotient;
                  default:   sat_in = sat_ff;
               endcase
               if (job_ff == JOB_SAT) begin
                  state_in = ST_FINISH;
               end else begin
                  job_in   = job_ff + 3'd1;
                  state_in = ST_LOAD;
               end
            end
         end
         ST_FINISH: begin
            // post only when the output register is free; otherwise hold
            if (rsp_free) begin
               rsp_in.color_code        = cls_ff.code;
               rsp_in.saturation_tenths = sat_ff;
               rsp_in.tone_start        = tone;
               rsp_in.tone_hz           = tone ? tone_hz_of(cls_ff.code) : 10'd0;
               rsp_in.brightness        = br_ff;
               rsp_in.led_red           = led_r_ff;
               rsp_in.led_green         = led_g_ff;
               rsp_in.led_blue          = led_b_ff;
               rsp_in.low_light         = low;
               rsp_in.alert_start       = low && !alert_latched_ff;
               rsp_valid_in             = 1'b1;
               if (tone) last_ann_in = cls_ff.code;
               alert_latched_in = low;
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         job_ff           <= JOB_BRIGHT;
         last_ann_ff      <= NONE_ANNOUNCED;
         alert_latched_ff <= 1'b0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         state_ff         <= state_in;
         job_ff           <= job_in;
         last_ann_ff      <= last_ann_in;
         alert_latched_ff <= alert_latched_in;
         rsp_valid_ff     <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff  <= item_in;
      cls_ff   <= cls_in;
      br_ff    <= br_in;
      led_r_ff <= led_r_in;
      led_g_ff <= led_g_in;
      led_b_ff <= led_b_in;
      sat_ff   <= sat_in;
      rsp_ff   <= rsp_in;
   end

   // the divider reports only while the sequencer waits for it
   a_done_in_run: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> state_ff == ST_RUN)
      else $error("divider finished outside the run step");

   // a tone is never sounded for dark or undefined samples
   a_tone_named: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.tone_start |->
         rsp_ff.color_code != COLOR_DARK && rsp_ff.color_code != COLOR_UNDEF &&
         rsp_ff.tone_hz != 10'd0)
      else $error("tone posted for an unnamed color");

   // an alert only opens a low-light period
   a_alert_low: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.alert_start |-> rsp_ff.low_light)
      else $error("alert without low light");

   // a new result is posted only into a free output register
   a_post_free: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FINISH && state_in == ST_IDLE |-> rsp_free)
      else $error("result overwrote a pending item");

   a_bright_floor: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_ff.brightness >= BRIGHT_MIN)
      else $error("brightness below floor");

endmodule
